>>> sv/sst_pkg.sv
// shared types and constants for the sorted set table
package sst_pkg;

  // default sizing
  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // fixed field widths
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_COMMIT,
    ST_DONE
  } state_t;

endpackage

>>> sv/sst_ram.sv
// element store: one write port, one registered read port
module sst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sorted_set_table.sv
// sorted set table: keeps distinct signed elements in order, add/remove/search
//
// Usage: an item on the in_ channel (in_operation, in_element) is taken when
// in_valid and in_ready are both high. in_ready is high only while the
// sequencer is idle; one item is worked at a time. Each item gives exactly one
// result on the out_ channel (out_status, out_element_count, out_is_empty),
// taken when out_valid and out_ready are both high.
// Operation: the sequencer scans every held entry through the single read
// port of the element store, one entry per cycle, then moves entries one at a
// time (read, then write) to open or close a gap, then commits and presents
// the result. in_ready returns with the result, so no new item is taken
// until the sequencer is through with the last one.
// The result register lets the next item be taken while a result waits; if
// the receiver stalls, a second finished result holds in the sequencer until
// the output register frees up, and no further item is taken meanwhile.
// Reset (rst_n low, synchronous) empties the set and selects ascending order.
// cfg_we/cfg_wdata set the order; write it only while the block is idle.
module sorted_set_table
  import sst_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [OP_W-1:0]                 in_operation,
  input  logic signed [ELEMENT_WIDTH-1:0] in_element,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic [COUNT_OUT_W-1:0]          out_element_count,
  output logic                            out_is_empty
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  state_t state_r, state_nxt;

  logic                     order_desc_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic [ELEMENT_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [CNT_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic                     hit_found_r, hit_found_nxt;
  logic [CNT_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic                     pos_found_r, pos_found_nxt;
  logic [CNT_W-1:0]         pos_idx_r, pos_idx_nxt;
  logic                     up_r, up_nxt;
  logic [CNT_W-1:0]         sh_r, sh_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [COUNT_OUT_W-1:0]   out_count_r, out_count_nxt;
  logic                     out_empty_r, out_empty_nxt;

  // store port signals
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ELEMENT_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ELEMENT_WIDTH-1:0] rd_data;

  // shared compare unit and loop conditions
  logic             scan_issue;
  logic             key_eq;
  logic             key_prec;
  logic             shift_more;
  logic             out_free;
  logic [CNT_W-1:0] sh_dn;
  logic [CNT_W-1:0] sh_up;

  assign scan_issue = (scan_idx_r < count_r);
  assign key_eq     = (key_r == rd_data);
  assign key_prec   = order_desc_r ? (key_r > rd_data) : (key_r < rd_data);
  assign sh_dn      = sh_r - ONE_CNT;
  assign sh_up      = sh_r + ONE_CNT;
  assign shift_more = up_r ? (sh_r > pos_idx_r) : (sh_up < count_r);
  assign out_free   = !out_valid_r || out_ready;

  sst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_issue && !pend_r) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        case (op_r)
          OP_ADD: begin
            if (hit_found_r || count_r >= CAP_CNT) state_nxt = ST_DONE;
            else state_nxt = ST_SHIFT_RD;
          end
          OP_REMOVE: begin
            state_nxt = hit_found_r ? ST_SHIFT_RD : ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SHIFT_RD: begin
        state_nxt = shift_more ? ST_SHIFT_WR : ST_COMMIT;
      end
      ST_SHIFT_WR: state_nxt = ST_SHIFT_RD;
      ST_COMMIT:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    pos_found_nxt  = pos_found_r;
    pos_idx_nxt    = pos_idx_r;
    up_nxt         = up_r;
    sh_nxt         = sh_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    ram_we         = 1'b0;
    ram_waddr      = sh_r[IDX_W-1:0];
    ram_wdata      = rd_data;
    ram_raddr      = scan_idx_r[IDX_W-1:0];

    case (state_r)
      // latch the item, keyed so unsigned compare gives signed order
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_operation;
          key_nxt       = {~in_element[ELEMENT_WIDTH-1], in_element[ELEMENT_WIDTH-2:0]};
          scan_idx_nxt  = '0;
          hit_found_nxt = 1'b0;
          pos_found_nxt = 1'b0;
        end
      end
      // one read per cycle, compare the entry read the cycle before
      ST_SCAN: begin
        pend_nxt     = scan_issue;
        pend_idx_nxt = scan_idx_r;
        if (scan_issue) scan_idx_nxt = scan_idx_r + ONE_CNT;
        if (pend_r) begin
          if (key_eq && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = pend_idx_r;
          end
          if (key_prec && !pos_found_r) begin
            pos_found_nxt = 1'b1;
            pos_idx_nxt   = pend_idx_r;
          end
        end
      end
      // pick status or set up the shift
      ST_DECIDE: begin
        status_nxt = STATUS_OK;
        case (op_r)
          OP_ADD: begin
            if (hit_found_r) begin
              status_nxt = STATUS_MISS;
            end else if (count_r >= CAP_CNT) begin
              status_nxt = STATUS_FULL;
            end else begin
              up_nxt = 1'b1;
              sh_nxt = count_r;
              if (!pos_found_r) pos_idx_nxt = count_r;
            end
          end
          OP_REMOVE: begin
            if (hit_found_r) begin
              up_nxt = 1'b0;
              sh_nxt = hit_idx_r;
            end else begin
              status_nxt = STATUS_MISS;
            end
          end
          default: status_nxt = hit_found_r ? STATUS_OK : STATUS_MISS;
        endcase
      end
      // read the neighbor that moves into slot sh
      ST_SHIFT_RD: begin
        ram_raddr = up_r ? sh_dn[IDX_W-1:0] : sh_up[IDX_W-1:0];
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_r[IDX_W-1:0];
        ram_wdata = rd_data;
        sh_nxt    = up_r ? sh_dn : sh_up;
      end
      // place the new key or drop the last slot
      ST_COMMIT: begin
        if (up_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_idx_r[IDX_W-1:0];
          ram_wdata = key_r;
          count_nxt = count_r + ONE_CNT;
        end else begin
          count_nxt = count_r - ONE_CNT;
        end
      end
      // hand the result to the output register
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_OUT_W'(count_r);
          out_empty_nxt  = (count_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      order_desc_r <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (cfg_we) order_desc_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    scan_idx_r   <= scan_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    pos_found_r  <= pos_found_nxt;
    pos_idx_r    <= pos_idx_nxt;
    up_r         <= up_nxt;
    sh_r         <= sh_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;
  assign out_is_empty      = out_empty_r;

endmodule

>>> sv/sst_checker.sv
// port-level checks for the sorted set table, bound to the top level
module sst_checker
  import sst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    out_status,
  input logic [COUNT_OUT_W-1:0] out_element_count,
  input logic                   out_is_empty
);

  localparam logic [COUNT_OUT_W-1:0] CAP_OUT = COUNT_OUT_W'(CAPACITY);

  // reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken right after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_element_count) && $stable(out_is_empty))
    else $error("stalled result changed");

  // count and empty flag agree, and full means count at capacity
  if (CAPACITY < (1 << COUNT_OUT_W)) begin : g_count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_is_empty == (out_element_count == '0)))
      else $error("empty flag does not match count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_status == STATUS_FULL |-> out_element_count == CAP_OUT)
      else $error("full status below capacity");
  end

endmodule

bind sorted_set_table sst_checker #(
  .CAPACITY (CAPACITY)
) u_sst_checker (.*);

>>> dv/testbench.sv
// testbench for the sorted set table: directed and random add/remove/search with result checking
`timescale 1ns / 100ps

module testbench
  import sst_pkg::*;
();

  localparam int EW = ELEMENT_WIDTH_DEF;
  localparam int CAP = CAPACITY_DEF;
  localparam int POOL_N = 70;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 3 * CAP + 10;
  // code 3 is not assigned and acts as a search
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [EW-1:0] ELEM_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [EW-1:0] ELEM_MAX = {1'b0, {(EW-1){1'b1}}};

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
    logic                   is_empty;
  } set_result_t;

  // mirror of the set contents and the results they imply
  class set_scoreboard;
    logic signed [EW-1:0] held[$];
    bit                   descending;
    set_result_t          awaited[$];
    int                   failures;

    function void set_order(bit desc);
      descending = desc;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // apply one accepted request and queue the result it must give
    function void note_request(logic [OP_W-1:0] op, logic signed [EW-1:0] elem);
      int hit;
      int pos;
      set_result_t r;
      hit = -1;
      for (int i = 0; i < held.size(); i++) begin
        if (held[i] == elem) begin
          hit = i;
          break;
        end
      end
      r.status = STATUS_OK;
      case (op)
        OP_ADD: begin
          if (hit >= 0) r.status = STATUS_MISS;
          else if (held.size() >= CAP) r.status = STATUS_FULL;
          else begin
            pos = held.size();
            for (int i = 0; i < held.size(); i++) begin
              if (descending ? (elem > held[i]) : (elem < held[i])) begin
                pos = i;
                break;
              end
            end
            held.insert(pos, elem);
          end
        end
        OP_REMOVE: begin
          if (hit >= 0) held.delete(hit);
          else r.status = STATUS_MISS;
        end
        default: begin
          r.status = (hit >= 0) ? STATUS_OK : STATUS_MISS;
        end
      endcase
      r.count = COUNT_OUT_W'(held.size());
      r.is_empty = (held.size() == 0);
      awaited.push_back(r);
    endfunction

    // compare one result with the oldest one awaited
    function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_OUT_W-1:0] count,
                               logic is_empty);
      set_result_t r;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding: status %0d count %0d empty %0d",
               status, count, is_empty);
        failures++;
        return;
      end
      r = awaited.pop_front();
      if (status !== r.status) begin
        $error("status mismatch: expected %0d, got %0d", r.status, status);
        failures++;
      end
      if (count !== r.count) begin
        $error("element_count mismatch: expected %0d, got %0d", r.count, count);
        failures++;
      end
      if (is_empty !== r.is_empty) begin
        $error("is_empty mismatch: expected %0d, got %0d", r.is_empty, is_empty);
        failures++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [OP_W-1:0]        in_operation;
  logic signed [EW-1:0]   in_element;
  logic                   out_valid;
  logic                   out_ready;
  logic [STATUS_W-1:0]    out_status;
  logic [COUNT_OUT_W-1:0] out_element_count;
  logic                   out_is_empty;

  set_scoreboard sb;
  bit            no_idle;
  int            quiet_cycles = 0;
  int            results_taken = 0;

  sorted_set_table u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_element        (in_element),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // observe both channels and feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_operation, in_element);
      if (out_valid && out_ready) sb.check_result(out_status, out_element_count, out_is_empty);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // result receiver with random stalls and a few long holds
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (results_taken == 100 || results_taken == 350) begin
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_taken++;
    end
  end

  // offer one request and hold it until taken
  task automatic send_request(logic [OP_W-1:0] op, logic signed [EW-1:0] elem);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_element   <= elem;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_order(bit desc);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= desc;
    sb.set_order(desc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random phase: optional fill from the pool, then a weighted mix
  task automatic run_phase(bit desc, bit quiet, int n_items, int add_pct, int rem_pct,
                           bit prefill);
    logic signed [EW-1:0] pool[POOL_N];
    logic [OP_W-1:0]      op;
    logic signed [EW-1:0] elem;
    int                   roll;
    int                   sent;
    settle();
    write_order(desc);
    no_idle = quiet;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = ELEM_MIN;
    pool[1] = ELEM_MAX;
    pool[2] = '0;
    pool[3] = -1;
    sent = 0;
    // more pool values than capacity, so the tail of the fill hits full
    if (prefill) begin
      foreach (pool[i]) begin
        send_request(OP_ADD, pool[i]);
        sent++;
      end
    end
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) op = OP_ADD;
      else if (roll < add_pct + rem_pct) op = OP_REMOVE;
      else op = ($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_SEARCH;
      elem = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_N - 1)];
      send_request(op, elem);
      sent++;
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_ADD;
    in_element    = '0;
    out_ready     = 1'b0;
    no_idle       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty set, extremes, duplicates, misses, unused code
    send_request(OP_SEARCH, '0);
    send_request(OP_REMOVE, 5);
    send_request(OP_ADD, ELEM_MIN);
    send_request(OP_ADD, ELEM_MAX);
    send_request(OP_ADD, '0);
    send_request(OP_ADD, -1);
    send_request(OP_ADD, 1);
    send_request(OP_ADD, ELEM_MAX);
    send_request(OP_SEARCH, ELEM_MIN);
    send_request(OP_SEARCH, 12345);
    send_request(OP_UNUSED, -1);
    send_request(OP_UNUSED, 42);
    send_request(OP_REMOVE, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_ADD, 32'h5555_5555);
    send_request(OP_ADD, 32'haaaa_aaaa);
    send_request(OP_REMOVE, ELEM_MIN);
    send_request(OP_REMOVE, ELEM_MAX);
    send_request(OP_REMOVE, -1);
    send_request(OP_REMOVE, 1);
    send_request(OP_REMOVE, 32'h5555_5555);
    send_request(OP_REMOVE, 32'haaaa_aaaa);

    // random phases, order flipped while elements are held
    run_phase(1'b1, 1'b0, 140, 40, 30, 1'b1);
    run_phase(1'b0, 1'b1, 100, 30, 50, 1'b0);
    run_phase(1'b1, 1'b0, 150, 50, 30, 1'b1);
    run_phase(1'b0, 1'b0, 140, 35, 45, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
sv/sst_pkg.sv
sv/sst_ram.sv
sv/sorted_set_table.sv
sv/sst_checker.sv
dv/testbench.sv
